>>> design/sensor_motor_heater_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor motor heater controller
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MOTOR_HEATER_CONTROLLER_ASSERT_SVH
`define SENSOR_MOTOR_HEATER_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define SMHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SMHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/smhc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor motor heater controller package
// Payload types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package smhc_pkg;

    localparam int AVG_COUNT   = 5;
    localparam int SAMPLE_BITS = 10;
    localparam int CFG_BITS    = 10;
    localparam int CFG_IDX_BITS = 2;
    localparam int DUTY_BITS   = 7;

    localparam int SUM_BITS  = $clog2(AVG_COUNT * ((2 ** SAMPLE_BITS) - 1) + 1);
    localparam int CNT_BITS  = $clog2(AVG_COUNT + 1);
    localparam int CMP_BITS  = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int RECIP_VALUE = ((2 ** RECIP_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
    localparam int MULT_BITS   = SUM_BITS + RECIP_BITS;

    localparam int FACTOR_BITS = 7;
    localparam int PROD_BITS   = SAMPLE_BITS + FACTOR_BITS;

    localparam logic [FACTOR_BITS-1:0] K_LIGHT_UNIT = 7'd5;
    localparam logic [FACTOR_BITS-1:0] K_LIGHT_HIGH = 7'd6;
    localparam logic [FACTOR_BITS-1:0] K_LIGHT_LOW  = 7'd4;
    localparam logic [FACTOR_BITS-1:0] K_LADDER_UNIT = 7'd10;
    localparam logic [FACTOR_BITS-1:0] K_HEAT_UNIT  = 7'd100;
    localparam logic [FACTOR_BITS-1:0] K_HEAT_BAND  = 7'd103;

    localparam logic [DUTY_BITS-1:0] DUTY_OFF  = 7'd0;
    localparam logic [DUTY_BITS-1:0] DUTY_DIM  = 7'd10;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = 7'd100;

    localparam int LADDER_LEN = 7;
    localparam logic [FACTOR_BITS-1:0] LADDER_FACTOR [LADDER_LEN] =
        '{7'd33, 7'd28, 7'd25, 7'd22, 7'd19, 7'd17, 7'd14};
    localparam logic [DUTY_BITS-1:0] LADDER_DUTY [LADDER_LEN] =
        '{7'd18, 7'd17, 7'd16, 7'd15, 7'd14, 7'd13, 7'd12};

    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_LEVEL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_LEVEL   = 2'd2;

    localparam logic [CFG_BITS-1:0] RST_BLOCK_LEVEL   = 10'd550;
    localparam logic [CFG_BITS-1:0] RST_RELEASE_LEVEL = 10'd800;
    localparam logic [CFG_BITS-1:0] RST_PRESS_LEVEL   = 10'd500;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] light_sample;
        logic [SAMPLE_BITS-1:0] touch_sample;
        logic [SAMPLE_BITS-1:0] heat_sample;
    } t_sample;

    typedef struct packed {
        logic [DUTY_BITS-1:0] motor_duty;
        logic                 direction_forward;
        logic                 heater_on;
    } t_result;

    typedef struct packed {
        logic [SUM_BITS-1:0] light;
        logic [SUM_BITS-1:0] touch;
        logic [SUM_BITS-1:0] heat;
    } t_sums;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] light;
        logic [SAMPLE_BITS-1:0] touch;
        logic [SAMPLE_BITS-1:0] heat;
    } t_avgs;

    function automatic logic [PROD_BITS-1:0] mul_const(
        input logic [SAMPLE_BITS-1:0] value,
        input logic [FACTOR_BITS-1:0] factor
    );
        return PROD_BITS'(value) * PROD_BITS'(factor);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] div_avg(input logic [SUM_BITS-1:0] sum);
        logic [MULT_BITS-1:0] prod;
        prod = MULT_BITS'(sum) * MULT_BITS'(RECIP_VALUE);
        return prod[RECIP_SHIFT +: SAMPLE_BITS];
    endfunction

endpackage

>>> design/sensor_motor_heater_controller.sv
// ----------------------------------------------------------------------------
// Sensor motor heater controller
// Averages groups of light, touch and temperature samples and derives the
// motor duty, motor direction and heater drive from each group average.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  in       i_in_valid / o_in_stall    i_in_data  (smhc_pkg::t_sample)
//  out      o_out_valid / i_out_stall  o_out_data (smhc_pkg::t_result)
//  cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One sample set is accepted per cycle while o_in_stall is low; every fifth set produces a result.
//  A result is valid once the set completing its group has passed the sum
//  register, the averaging multiply into the average register, then decision
//  logic into the result register.
//  Reset is synchronous and restores defaults; sum/avg/result data are not reset.
//  A stalled result blocks input only once the pipeline behind it is full.
// ----------------------------------------------------------------------------
`include "sensor_motor_heater_controller_assert.svh"

module sensor_motor_heater_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  smhc_pkg::t_sample                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output smhc_pkg::t_result                 o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smhc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [smhc_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import smhc_pkg::*;

    logic [CFG_BITS-1:0]    r_block_level;
    logic [CFG_BITS-1:0]    r_release_level;
    logic [CFG_BITS-1:0]    r_press_level;

    t_sums                  r_acc;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_sum_valid;
    t_sums                  r_sum;
    logic                   r_avg_valid;
    t_avgs                  r_avg;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   r_base_taken;
    logic [SAMPLE_BITS-1:0] r_light_base;
    logic [SAMPLE_BITS-1:0] r_heat_base;
    logic [DUTY_BITS-1:0]   r_duty;
    logic                   r_latched;
    logic                   r_dir;
    logic                   r_heater;

    logic                   out_ready;
    logic                   avg_ready;
    logic                   sum_ready;
    logic                   in_accept;
    logic                   group_done;
    t_sums                  tot;

    logic [SAMPLE_BITS-1:0] light_base;
    logic [SAMPLE_BITS-1:0] heat_base;
    logic [PROD_BITS-1:0]   light5;
    logic [PROD_BITS-1:0]   light10;
    logic [PROD_BITS-1:0]   heat100;
    logic [PROD_BITS-1:0]   heat103;
    logic [DUTY_BITS-1:0]   n_duty;
    logic                   n_latched;
    logic                   n_dir;
    logic                   n_heater;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign avg_ready  = !r_avg_valid || out_ready;
    assign sum_ready  = !r_sum_valid || avg_ready;
    assign o_in_stall = !sum_ready;
    assign in_accept  = i_in_valid && sum_ready;
    assign group_done = (r_cnt == CNT_BITS'(AVG_COUNT - 1));

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        tot.light = r_acc.light + SUM_BITS'(i_in_data.light_sample);
        tot.touch = r_acc.touch + SUM_BITS'(i_in_data.touch_sample);
        tot.heat  = r_acc.heat + SUM_BITS'(i_in_data.heat_sample);
    end

    always_comb begin
        light_base = r_base_taken ? r_light_base : r_avg.light;
        heat_base  = r_base_taken ? r_heat_base : r_avg.heat;
        light5     = mul_const(r_avg.light, K_LIGHT_UNIT);
        light10    = mul_const(r_avg.light, K_LADDER_UNIT);
        heat100    = mul_const(r_avg.heat, K_HEAT_UNIT);
        heat103    = mul_const(heat_base, K_HEAT_BAND);

        n_duty = r_duty;
        for (int i = LADDER_LEN - 1; i >= 0; i--) begin
            if (light10 > mul_const(light_base, LADDER_FACTOR[i])) begin
                n_duty = LADDER_DUTY[i];
            end
        end
        if (CMP_BITS'(r_avg.light) >= CMP_BITS'(r_block_level)) begin
            n_duty = DUTY_FULL;
        end
        if (light5 < mul_const(light_base, K_LIGHT_LOW)) begin
            n_duty = DUTY_OFF;
        end else if (light5 < mul_const(light_base, K_LIGHT_HIGH)) begin
            n_duty = DUTY_DIM;
        end

        n_latched = r_latched;
        n_dir     = r_dir;
        if (CMP_BITS'(r_avg.touch) > CMP_BITS'(r_release_level)) begin
            n_latched = 1'b0;
        end
        if (CMP_BITS'(r_avg.touch) <= CMP_BITS'(r_press_level) && !n_latched) begin
            n_dir     = !r_dir;
            n_latched = 1'b1;
        end

        n_heater = r_heater;
        if (!(r_avg.heat > heat_base && heat100 < heat103)) begin
            if (heat100 >= heat103) begin
                n_heater = 1'b1;
            end
            if (r_avg.heat <= heat_base) begin
                n_heater = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_level   <= RST_BLOCK_LEVEL;
            r_release_level <= RST_RELEASE_LEVEL;
            r_press_level   <= RST_PRESS_LEVEL;
            r_acc           <= '0;
            r_cnt           <= '0;
            r_sum_valid     <= 1'b0;
            r_avg_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_base_taken    <= 1'b0;
            r_light_base    <= '0;
            r_heat_base     <= '0;
            r_duty          <= '0;
            r_latched       <= 1'b0;
            r_dir           <= 1'b0;
            r_heater        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BLOCK_LEVEL:   r_block_level   <= i_cfg_data;
                    CFG_RELEASE_LEVEL: r_release_level <= i_cfg_data;
                    CFG_PRESS_LEVEL:   r_press_level   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (in_accept) begin
                if (group_done) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= tot;
                    r_cnt <= r_cnt + CNT_BITS'(1);
                end
            end

            if (in_accept && group_done) begin
                r_sum_valid <= 1'b1;
            end else if (avg_ready) begin
                r_sum_valid <= 1'b0;
            end

            if (avg_ready) begin
                r_avg_valid <= r_sum_valid;
            end

            if (out_ready) begin
                r_out_valid <= r_avg_valid;
            end

            if (r_avg_valid && out_ready) begin
                r_base_taken <= 1'b1;
                r_light_base <= light_base;
                r_heat_base  <= heat_base;
                r_duty       <= n_duty;
                r_latched    <= n_latched;
                r_dir        <= n_dir;
                r_heater     <= n_heater;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && group_done) begin
            r_sum <= tot;
        end
        if (r_sum_valid && avg_ready) begin
            r_avg.light <= div_avg(r_sum.light);
            r_avg.touch <= div_avg(r_sum.touch);
            r_avg.heat  <= div_avg(r_sum.heat);
        end
        if (r_avg_valid && out_ready) begin
            r_out.motor_duty        <= n_duty;
            r_out.direction_forward <= n_dir;
            r_out.heater_on         <= n_heater;
        end
    end

    `SMHC_ASSERT_SAME(a_duty_range, i_clk, i_rst_n, r_out_valid, r_out.motor_duty <= DUTY_FULL, "motor duty above full scale")
    `SMHC_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt < CNT_BITS'(AVG_COUNT), "group count out of range")
    `SMHC_ASSERT_NEXT(a_group_load, i_clk, i_rst_n, in_accept && group_done, r_sum_valid, "completed group not loaded")
    `SMHC_ASSERT_NEXT(a_dir_hold, i_clk, i_rst_n, !(r_avg_valid && out_ready), $stable(r_dir), "direction changed without a result")

endmodule
